[design/ptts_pkg.sv]
// ----------------------------------------------------------------------------
// ptts_pkg: shared types and constants of the periodic task tick scheduler
// Holds the item kind codes, field widths and the layout of one task table entry.
// ----------------------------------------------------------------------------
package ptts_pkg;

    localparam int CNT_W       = 16;
    localparam int SLOT_W      = 8;
    localparam int TASK_IDX_W  = 6;
    localparam int MAX_RESULTS = 8;
    localparam int RES_CNT_W   = 4;

    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_CREATE = 1'b1;

    typedef logic [CNT_W-1:0] cnt_t;

    // One task table entry as it is stored in memory.
    typedef struct packed {
        cnt_t period;
        cnt_t countdown;
    } entry_t;

endpackage

[design/periodic_task_tick_scheduler.sv]
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler: time triggered cooperative task scheduler
// A task table in synchronous memory, walked slot by slot on every tick.
// ----------------------------------------------------------------------------
// A create word is written in the cycle it is accepted and gives no result.
// A tick walks the table, one slot per cycle while the output side does not stall the
// walk, and ends with a final word marked last.
// One create per cycle while idle; a new tick is not taken until the previous one has
// given its final word. Reset (aresetn low, synchronous) clears all valid and
// entry-written bits at once, so every slot reads as zero with no handler.
module periodic_task_tick_scheduler #(
    parameter int TASKS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_kind,
    input  logic [ptts_pkg::SLOT_W-1:0]     s_slot,
    input  logic [ptts_pkg::CNT_W-1:0]      s_period,
    input  logic [ptts_pkg::CNT_W-1:0]      s_first_delay,
    input  logic                            s_has_handler,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ptts_pkg::TASK_IDX_W-1:0] m_task_index,
    output logic                            m_fired,
    output logic                            m_last
);
    import ptts_pkg::*;

    // Index width of the table and width of the walk counter, which must
    // also hold TASKS itself to mark the end of the walk.
    localparam int IW = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int CW = $clog2(TASKS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    // The task table. Each entry holds the reload period and the countdown.
    // An entry that has never been written reads as zero through init_reg.
    entry_t entry_mem [TASKS];

    logic [1:0]           state_reg, state_next;
    logic [CW-1:0]        rd_cnt_reg, rd_cnt_next;
    logic                 p_valid_reg, p_valid_next;
    logic [IW-1:0]        p_idx_reg, p_idx_next;
    entry_t               rd_data_reg;
    logic [TASKS-1:0]     valid_reg, valid_next;
    logic [TASKS-1:0]     init_reg, init_next;
    logic [RES_CNT_W-1:0] res_cnt_reg, res_cnt_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [IW-1:0]        pend_idx_reg, pend_idx_next;
    logic                 m_valid_reg, m_valid_next;
    logic [TASK_IDX_W-1:0] m_idx_reg, m_idx_next;
    logic                 m_fired_reg, m_fired_next;
    logic                 m_last_reg, m_last_next;

    entry_t               entry;
    cnt_t                 new_cd;
    logic                 out_free;
    logic                 fire;
    logic                 stall;
    logic                 issue;
    logic                 wb_en;
    logic                 cr_en;
    logic                 mem_we;
    logic [IW-1:0]        mem_waddr;
    entry_t               mem_wdata;

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_task_index = m_idx_reg;
    assign m_fired      = m_fired_reg;
    assign m_last       = m_last_reg;

    // The output register is free when empty or when its word leaves now.
    assign out_free = !m_valid_reg || m_ready;

    // Processing stage: the entry held in the read data register.
    assign entry  = init_reg[p_idx_reg] ? rd_data_reg : '0;
    assign new_cd = (entry.countdown == '0) ? (entry.period - 1'b1)
                                            : (entry.countdown - 1'b1);
    assign fire   = p_valid_reg && (entry.countdown == '0) && valid_reg[p_idx_reg]
                    && (res_cnt_reg < RES_CNT_W'(MAX_RESULTS));

    // A firing slot pushes the previously held firing to the output. If the
    // output register is still occupied the walk pauses; the read data
    // register holds because no new read is issued.
    assign stall = fire && pend_valid_reg && !out_free;
    assign wb_en = (state_reg == ST_WALK) && p_valid_reg && !stall;
    assign issue = (state_reg == ST_WALK) && (rd_cnt_reg < CW'(TASKS)) && !stall;

    assign cr_en = (state_reg == ST_IDLE) && s_valid && (s_kind == KIND_CREATE)
                   && s_has_handler && (s_slot < SLOT_W'(TASKS));

    // Create and write-back never overlap: creates are taken only when idle.
    assign mem_we    = cr_en || wb_en;
    assign mem_waddr = cr_en ? s_slot[IW-1:0] : p_idx_reg;
    assign mem_wdata = cr_en ? entry_t'{period: s_period, countdown: s_first_delay}
                             : entry_t'{period: entry.period, countdown: new_cd};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_data_reg <= entry_mem[rd_cnt_reg[IW-1:0]];
        end
    end

    always_comb begin
        state_next      = state_reg;
        rd_cnt_next     = rd_cnt_reg;
        p_valid_next    = p_valid_reg;
        p_idx_next      = p_idx_reg;
        valid_next      = valid_reg;
        init_next       = init_reg;
        res_cnt_next    = res_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_idx_next      = m_idx_reg;
        m_fired_next    = m_fired_reg;
        m_last_next     = m_last_reg;

        if (cr_en) begin
            valid_next[s_slot[IW-1:0]] = 1'b1;
            init_next[s_slot[IW-1:0]]  = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && (s_kind == KIND_TICK)) begin
                    state_next      = ST_WALK;
                    rd_cnt_next     = '0;
                    p_valid_next    = 1'b0;
                    res_cnt_next    = '0;
                    pend_valid_next = 1'b0;
                end
            end
            ST_WALK: begin
                if (!stall) begin
                    p_valid_next = issue;
                    if (issue) begin
                        p_idx_next  = rd_cnt_reg[IW-1:0];
                        rd_cnt_next = rd_cnt_reg + 1'b1;
                    end
                end
                if (wb_en) begin
                    init_next[p_idx_reg] = 1'b1;
                    if (fire) begin
                        // Hand the earlier firing on; it is known not to be last.
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_idx_next   = TASK_IDX_W'(pend_idx_reg);
                            m_fired_next = 1'b1;
                            m_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = p_idx_reg;
                        res_cnt_next    = res_cnt_reg + 1'b1;
                    end
                end
                if (!issue && !p_valid_reg && (rd_cnt_reg == CW'(TASKS))) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_idx_next      = pend_valid_reg ? TASK_IDX_W'(pend_idx_reg) : '0;
                    m_fired_next    = pend_valid_reg;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            rd_cnt_reg     <= '0;
            p_valid_reg    <= 1'b0;
            valid_reg      <= '0;
            init_reg       <= '0;
            res_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            rd_cnt_reg     <= rd_cnt_next;
            p_valid_reg    <= p_valid_next;
            valid_reg      <= valid_next;
            init_reg       <= init_next;
            res_cnt_reg    <= res_cnt_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_idx_reg    <= p_idx_next;
        pend_idx_reg <= pend_idx_next;
        m_idx_reg    <= m_idx_next;
        m_fired_reg  <= m_fired_next;
        m_last_reg   <= m_last_next;
    end

`ifndef NO_ASSERTIONS
    a_res_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        res_cnt_reg <= RES_CNT_W'(MAX_RESULTS))
        else $error("more firings counted than can be reported");

    a_pend_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (res_cnt_reg != '0))
        else $error("held firing without a counted result");

    a_nofire_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_fired_reg) |-> (m_last_reg && (m_idx_reg == '0)))
        else $error("empty tick word not marked last or has an index");

    a_tick_starts_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_kind == KIND_TICK)) |=> (state_reg == ST_WALK))
        else $error("accepted tick did not start the table walk");

    a_no_write_in_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH) |-> !mem_we)
        else $error("task memory written while flushing");
`endif

endmodule
